// ===== sv/lld_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lld_pkg
// Shared types, constants and helpers of the least-loaded dispatcher.
// ----------------------------------------------------------------------------
package lld_pkg;

	localparam int MAX_WORKERS_DEF = 8;
	localparam int WEIGHT_W        = 32;
	localparam int APB_AW          = 3;
	localparam int APB_DW          = 32;

	localparam logic       REQ_DISPATCH = 1'b0;
	localparam logic       REQ_REPORT   = 1'b1;
	localparam logic [0:0] REG_ACTIVE   = 1'b0;
	localparam logic [3:0] ACTIVE_RESET = 4'd8;

	localparam logic [16:0] HEADER_WORDS = 17'd3;

	typedef struct packed {
		logic        req_type;
		logic [15:0] seg_words;
		logic [2:0]  worker;
		logic [31:0] reported_weight;
	} req_t;

	typedef struct packed {
		logic [2:0]  target_worker;
		logic [6:0]  win_count;
		logic [18:0] packet_bytes;
		logic [31:0] outstanding;
	} res_t;

	// size / 768 = (size >> 8) / 3, by reciprocal 171/512 (exact below 512)
	function automatic logic [6:0] windows_of(input logic [15:0] size);
		logic [16:0] prod;
		prod = 17'(size[15:8]) * 17'd171;
		return prod[15:9];
	endfunction

	// (size + 3) * 4
	function automatic logic [18:0] bytes_of(input logic [15:0] size);
		logic [16:0] words;
		words = 17'(size) + HEADER_WORDS;
		return {words, 2'b00};
	endfunction

endpackage

// ===== sv/lld_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lld_req_if
// Request channel: dispatch or weight report, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lld_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [15:0] seg_words;
	logic [2:0]  worker;
	logic [31:0] reported_weight;

	modport source (output valid, output req_type, output seg_words, output worker,
		output reported_weight, input ready);
	modport sink (input valid, input req_type, input seg_words, input worker,
		input reported_weight, output ready);
endinterface

// ===== sv/lld_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lld_rsp_if
// Result channel: one result per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lld_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  target_worker;
	logic [6:0]  win_count;
	logic [18:0] packet_bytes;
	logic [31:0] outstanding;

	modport source (output valid, output target_worker, output win_count,
		output packet_bytes, output outstanding, input ready);
	modport sink (input valid, input target_worker, input win_count,
		input packet_bytes, input outstanding, output ready);
endinterface

// ===== sv/lld_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lld_cfg
// APB register port holding the active worker count.
// ----------------------------------------------------------------------------
module lld_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [lld_pkg::APB_AW-1:0] paddr,
	input  logic [lld_pkg::APB_DW-1:0] pwdata,
	output logic [lld_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	output logic [3:0]                 active_children
);

	logic [3:0] active_q;
	logic       hit;

	assign hit    = (paddr[lld_pkg::APB_AW-1:2] == lld_pkg::REG_ACTIVE);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= lld_pkg::ACTIVE_RESET;
		end else if (psel && penable && pwrite && pready && hit) begin
			active_q <= pwdata[3:0];
		end
	end

	assign prdata          = hit ? lld_pkg::APB_DW'(active_q) : '0;
	assign active_children = active_q;

endmodule

// ===== sv/lld_wtab.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lld_wtab
// Worker weight memory, one write and one registered read port, with
// per-entry valid bits so that reset reads back zero weights.
// ----------------------------------------------------------------------------
module lld_wtab #(
	parameter int DEPTH = lld_pkg::MAX_WORKERS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [AW-1:0]                rd_addr,
	output logic [lld_pkg::WEIGHT_W-1:0] rd_data,
	input  logic                         wr_en,
	input  logic [AW-1:0]                wr_addr,
	input  logic [lld_pkg::WEIGHT_W-1:0] wr_data
);

	logic [lld_pkg::WEIGHT_W-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0]             valid_q;
	logic [lld_pkg::WEIGHT_W-1:0] rd_mem_q;
	logic                         rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_mem_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_vld_q <= valid_q[rd_addr];
		end
	end

	assign rd_data = rd_vld_q ? rd_mem_q : '0;

endmodule

// ===== sv/lld_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lld_seq
// Request sequencer: for a dispatch, walks the weight table with one comparator
// to find the least-loaded worker; then updates the table and outstanding count.
// ----------------------------------------------------------------------------
module lld_seq #(
	parameter int MAX_WORKERS = lld_pkg::MAX_WORKERS_DEF,
	parameter int IW          = $clog2(MAX_WORKERS)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [3:0]                   active_children,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  lld_pkg::req_t                in_req,
	input  logic                         slot_free,
	output logic                         done,
	output lld_pkg::res_t                res,
	output logic [IW-1:0]                rd_addr,
	input  logic [lld_pkg::WEIGHT_W-1:0] rd_data,
	output logic                         wr_en,
	output logic [IW-1:0]                wr_addr,
	output logic [lld_pkg::WEIGHT_W-1:0] wr_data
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_WRITE = 2'd2;

	logic [1:0]                   state_q;
	logic [IW-1:0]                idx_q;
	logic [IW-1:0]                last_q;
	logic [IW-1:0]                best_q;
	logic [lld_pkg::WEIGHT_W-1:0] bestw_q;
	logic                         req_q;
	logic [2:0]                   wk_q;
	logic                         wk_ok_q;
	logic [6:0]                   windows_q;
	logic [18:0]                  bytes_q;
	logic [lld_pkg::WEIGHT_W-1:0] rep_q;
	logic [31:0]                  outstanding_q;

	logic                         accept;
	logic                         take;
	logic                         finish;
	logic [IW-1:0]                last_c;
	logic [31:0]                  ac32;
	logic [32:0]                  sum;
	logic [lld_pkg::WEIGHT_W-1:0] sat;
	logic [31:0]                  outstanding_c;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign take     = (idx_q == '0) || (rd_data < bestw_q);
	assign finish   = (state_q == ST_WRITE) && slot_free;

	always_comb begin
		ac32 = 32'(active_children);
		if (ac32 == 32'd0) begin
			last_c = '0;
		end else if (ac32 > 32'(MAX_WORKERS)) begin
			last_c = IW'(MAX_WORKERS - 1);
		end else begin
			last_c = IW'(ac32 - 32'd1);
		end
	end

	always_comb begin
		unique case (state_q)
			ST_IDLE: rd_addr = '0;
			ST_SCAN: rd_addr = idx_q + IW'(1);
			default: rd_addr = idx_q;
		endcase
	end

	always_comb begin
		sum = {1'b0, bestw_q} + 33'(windows_q);
		sat = sum[32] ? '1 : sum[31:0];
		if (req_q == lld_pkg::REQ_DISPATCH) begin
			outstanding_c = outstanding_q + 32'(windows_q);
		end else begin
			outstanding_c = outstanding_q - 32'(windows_q);
		end
	end

	assign wr_en   = finish && ((req_q == lld_pkg::REQ_DISPATCH) || wk_ok_q);
	assign wr_addr = best_q;
	assign wr_data = (req_q == lld_pkg::REQ_DISPATCH) ? sat : rep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			outstanding_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (in_req.req_type == lld_pkg::REQ_DISPATCH) ?
							ST_SCAN : ST_WRITE;
					end
				end
				ST_SCAN: begin
					if (idx_q == last_q) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (finish) begin
						state_q       <= ST_IDLE;
						outstanding_q <= outstanding_c;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q     <= '0;
			last_q    <= last_c;
			req_q     <= in_req.req_type;
			wk_q      <= in_req.worker;
			wk_ok_q   <= (32'(in_req.worker) < 32'(MAX_WORKERS));
			windows_q <= lld_pkg::windows_of(in_req.seg_words);
			bytes_q   <= lld_pkg::bytes_of(in_req.seg_words);
			rep_q     <= in_req.reported_weight;
			best_q    <= IW'(in_req.worker);
		end else if (state_q == ST_SCAN) begin
			idx_q <= idx_q + IW'(1);
			if (take) begin
				best_q  <= idx_q;
				bestw_q <= rd_data;
			end
		end
	end

	assign done              = finish;
	assign res.target_worker = (req_q == lld_pkg::REQ_DISPATCH) ? 3'(best_q) : wk_q;
	assign res.win_count     = windows_q;
	assign res.packet_bytes  = (req_q == lld_pkg::REQ_DISPATCH) ? bytes_q : '0;
	assign res.outstanding   = outstanding_c;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (state_q == ST_IDLE))
		else $error("sequencer did not return to idle after a result");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (idx_q <= last_q))
		else $error("scan index ran past the active worker count");

	a_pick_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (req_q == lld_pkg::REQ_DISPATCH)) |-> (best_q <= last_q))
		else $error("dispatch picked an inactive worker");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_IDLE) && !in_valid) |=> (state_q == ST_IDLE))
		else $error("sequencer left idle without a request");

endmodule

// ===== sv/least_loaded_dispatcher_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// least_loaded_dispatcher_top
// Least-loaded dispatcher: picks the lightest active worker for each
// dispatch request and tracks reported weights and outstanding windows.
// ----------------------------------------------------------------------------
// Dispatch: the single comparator walks the weight table one entry a cycle over
//   the active workers (1..MAX; zero active scans worker 0), then writes it back.
// Report: no scan; writes the reported weight. One request is in flight at a time;
//   the next is taken once the result has moved to the output register.
// Reset (arst_n low): weights read as zero, outstanding count zero,
//   active count eight, no result pending.
module least_loaded_dispatcher_top #(
	parameter int MAX_WORKERS = lld_pkg::MAX_WORKERS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [lld_pkg::APB_AW-1:0] paddr,
	input  logic [lld_pkg::APB_DW-1:0] pwdata,
	output logic [lld_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	lld_req_if.sink                    req,
	lld_rsp_if.source                  rsp
);

	localparam int IW = $clog2(MAX_WORKERS);

	logic [3:0]                   active_children;
	lld_pkg::req_t                in_req;
	lld_pkg::res_t                res;
	lld_pkg::res_t                rsp_q;
	logic                         rsp_valid_q;
	logic                         slot_free;
	logic                         done;
	logic [IW-1:0]                rd_addr;
	logic [lld_pkg::WEIGHT_W-1:0] rd_data;
	logic                         wr_en;
	logic [IW-1:0]                wr_addr;
	logic [lld_pkg::WEIGHT_W-1:0] wr_data;

	assign in_req.req_type        = req.req_type;
	assign in_req.seg_words       = req.seg_words;
	assign in_req.worker          = req.worker;
	assign in_req.reported_weight = req.reported_weight;

	assign slot_free = !rsp_valid_q || rsp.ready;

	lld_cfg u_cfg (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.active_children (active_children)
	);

	lld_wtab #(
		.DEPTH (MAX_WORKERS),
		.AW    (IW)
	) u_wtab (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	lld_seq #(
		.MAX_WORKERS (MAX_WORKERS),
		.IW          (IW)
	) u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.active_children (active_children),
		.in_valid        (req.valid),
		.in_ready        (req.ready),
		.in_req          (in_req),
		.slot_free       (slot_free),
		.done            (done),
		.res             (res),
		.rd_addr         (rd_addr),
		.rd_data         (rd_data),
		.wr_en           (wr_en),
		.wr_addr         (wr_addr),
		.wr_data         (wr_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.target_worker = rsp_q.target_worker;
	assign rsp.win_count     = rsp_q.win_count;
	assign rsp.packet_bytes  = rsp_q.packet_bytes;
	assign rsp.outstanding   = rsp_q.outstanding;

endmodule
